// ----- rtl/s2u_pkg.sv -----
package s2u_pkg;

  localparam int unsigned VALUE_WIDTH_DEF  = 32;
  localparam int unsigned OFFSET_WIDTH_DEF = 16;
  localparam int unsigned BASE_W           = 6;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_A_UP     = 8'h41;
  localparam logic [7:0] CH_Z_UP     = 8'h5A;
  localparam logic [7:0] CH_X_UP     = 8'h58;
  localparam logic [7:0] CH_X_LO     = 8'h78;
  localparam logic [7:0] CASE_BIT    = 8'h20;
  localparam logic [7:0] LETTER_BIAS = 8'h37; // 'A' - 10

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS,
    PH_STOPPED
  } s2u_phase_e;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] val;
  } s2u_digit_t;

  typedef struct packed {
    logic ok;   // byte was a digit below the base
    logic ovf;  // this step overflowed
  } s2u_mac_flags_t;

  function automatic s2u_digit_t digit_of(input logic [7:0] b);
    logic [7:0] up;
    s2u_digit_t r;
    up = b & ~CASE_BIT;
    r  = '0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      r.ok  = 1'b1;
      r.val = BASE_W'(b - CH_ZERO);
    end else if (up >= CH_A_UP && up <= CH_Z_UP) begin
      r.ok  = 1'b1;
      r.val = BASE_W'(up - LETTER_BIAS);
    end
    return r;
  endfunction

endpackage

// ----- rtl/s2u_mac.sv -----
module s2u_mac import s2u_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic [VALUE_WIDTH-1:0] acc_i,
  input  logic [BASE_W-1:0]      base_i,
  input  logic [7:0]             byte_i,
  output logic [VALUE_WIDTH-1:0] acc_o,
  output s2u_mac_flags_t         flags_o
);

  localparam int unsigned PROD_W = VALUE_WIDTH + BASE_W;

  s2u_digit_t             dig;
  logic [PROD_W-1:0]      prod;
  logic [VALUE_WIDTH:0]   sum;
  logic                   base_ok;

  assign dig     = digit_of(byte_i);
  assign base_ok = (base_i >= BASE_MIN) && (base_i <= BASE_MAX);

  // base-wide multiply, then add the digit; carries out of either mean overflow
  assign prod = {{BASE_W{1'b0}}, acc_i} * {{VALUE_WIDTH{1'b0}}, base_i};
  assign sum  = {1'b0, prod[VALUE_WIDTH-1:0]} + {{(VALUE_WIDTH + 1 - BASE_W){1'b0}}, dig.val};

  assign acc_o       = sum[VALUE_WIDTH-1:0];
  assign flags_o.ok  = base_ok && dig.ok && (dig.val < base_i);
  assign flags_o.ovf = (|prod[PROD_W-1:VALUE_WIDTH]) | sum[VALUE_WIDTH];

endmodule

// ----- rtl/string_to_unsigned_parser.sv -----
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o  | char_byte_i
// out     | output    | out_valid_o / out_stall_i | value_o, out_of_range_o, end_offset_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (number_base)
//
// one byte per cycle unless a NUL meets a stalled result; each byte is registered, then parsed
// a NUL byte's result passes the input register and then the result register before it transfers
// the accumulator update (one multiply-add by the radix) sets the cycle time
// out_stall_i holds the result register; a NUL then waits in the input register and stalls in
// rst_ni clears the parse state and sets number_base to automatic
module string_to_unsigned_parser import s2u_pkg::*; #(
  parameter int unsigned VALUE_WIDTH  = VALUE_WIDTH_DEF,
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              char_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [VALUE_WIDTH-1:0]  value_o,
  output logic                    out_of_range_o,
  output logic [OFFSET_WIDTH-1:0] end_offset_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [BASE_W-1:0]       cfg_data_i
);

  logic                    in_vld_q, in_vld_d;
  logic [7:0]              byte_q;
  logic [BASE_W-1:0]       cfg_base_q;

  s2u_phase_e              phase_q, phase_d;
  logic [VALUE_WIDTH-1:0]  acc_q, acc_d;
  logic                    ovf_q, ovf_d;
  logic                    minus_q, minus_d;
  logic [BASE_W-1:0]       abase_q, abase_d;
  logic                    dseen_q, dseen_d;
  logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
  logic [OFFSET_WIDTH-1:0] epos_q, epos_d;

  logic                    out_vld_q, out_vld_d;
  logic [VALUE_WIDTH-1:0]  value_q;
  logic                    oor_q;
  logic [OFFSET_WIDTH-1:0] eoff_q;

  logic                    out_free, advance, in_xfer;
  logic                    is_nul, is_ws, is_sign, is_x, cfg_auto, zero_pref;
  logic                    attempt, take_zero;
  logic [BASE_W-1:0]       try_base;
  logic [OFFSET_WIDTH-1:0] pos_next;
  logic [VALUE_WIDTH-1:0]  mac_acc;
  s2u_mac_flags_t          mac_flags;
  logic [VALUE_WIDTH-1:0]  result_val;

  // handshake
  assign out_free    = !out_vld_q || !out_stall_i;
  assign advance     = in_vld_q && (!is_nul || out_free);
  assign in_stall_o  = in_vld_q && !advance;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign in_vld_d    = in_xfer || (in_vld_q && !advance);
  assign cfg_ready_o = 1'b1;

  // byte classes
  assign is_nul    = (byte_q == CH_NUL);
  assign is_ws     = (byte_q == CH_SPACE) || (byte_q >= CH_TAB && byte_q <= CH_CR);
  assign is_sign   = (byte_q == CH_PLUS) || (byte_q == CH_MINUS);
  assign is_x      = (byte_q == CH_X_LO) || (byte_q == CH_X_UP);
  assign cfg_auto  = (cfg_base_q == BASE_AUTO);
  assign zero_pref = (byte_q == CH_ZERO) && (cfg_auto || cfg_base_q == BASE_HEX);
  assign pos_next  = (&pos_q) ? pos_q : pos_q + OFFSET_WIDTH'(1);

  always_comb begin
    try_base  = cfg_auto ? BASE_DEC : cfg_base_q;
    attempt   = 1'b0;
    take_zero = 1'b0;
    unique case (phase_q)
      PH_SPACE: begin
        take_zero = !is_ws && !is_sign && zero_pref;
        attempt   = !is_ws && !is_sign && !zero_pref;
      end
      PH_SIGNED: begin
        take_zero = zero_pref;
        attempt   = !zero_pref;
      end
      PH_ZERO: begin
        try_base = cfg_auto ? BASE_OCT : BASE_HEX;
        attempt  = !is_x;
      end
      PH_DIGITS: begin
        try_base = abase_q;
        attempt  = 1'b1;
      end
      default: begin
        attempt = 1'b0;
      end
    endcase
  end

  s2u_mac #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mac (
    .acc_i  (acc_q),
    .base_i (try_base),
    .byte_i (byte_q),
    .acc_o  (mac_acc),
    .flags_o(mac_flags)
  );

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (advance) begin
      if (is_nul) begin
        phase_d = PH_SPACE;
      end else begin
        unique case (phase_q)
          PH_SPACE: begin
            if (is_ws) begin
              phase_d = PH_SPACE;
            end else if (is_sign) begin
              phase_d = PH_SIGNED;
            end else if (zero_pref) begin
              phase_d = PH_ZERO;
            end else begin
              phase_d = mac_flags.ok ? PH_DIGITS : PH_STOPPED;
            end
          end
          PH_SIGNED: begin
            if (zero_pref) begin
              phase_d = PH_ZERO;
            end else begin
              phase_d = mac_flags.ok ? PH_DIGITS : PH_STOPPED;
            end
          end
          PH_ZERO: begin
            if (is_x) begin
              phase_d = PH_DIGITS;
            end else begin
              phase_d = mac_flags.ok ? PH_DIGITS : PH_STOPPED;
            end
          end
          PH_DIGITS: begin
            phase_d = mac_flags.ok ? PH_DIGITS : PH_STOPPED;
          end
          PH_STOPPED: begin
            phase_d = PH_STOPPED;
          end
          default: begin
            phase_d = PH_STOPPED;
          end
        endcase
      end
    end
  end

  // parse datapath
  always_comb begin
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    minus_d = minus_q;
    abase_d = abase_q;
    dseen_d = dseen_q;
    pos_d   = pos_q;
    epos_d  = epos_q;
    if (advance) begin
      if (is_nul) begin
        acc_d   = '0;
        ovf_d   = 1'b0;
        minus_d = 1'b0;
        abase_d = BASE_AUTO;
        dseen_d = 1'b0;
        pos_d   = '0;
        epos_d  = '0;
      end else begin
        pos_d = pos_next;
        if (phase_q == PH_SPACE && is_sign) begin
          minus_d = (byte_q == CH_MINUS);
        end
        if (phase_q == PH_ZERO && is_x) begin
          abase_d = BASE_HEX;
        end
        if (take_zero) begin
          acc_d   = '0;
          dseen_d = 1'b1;
          epos_d  = pos_next;
        end
        if (attempt) begin
          abase_d = try_base;
          if (mac_flags.ok) begin
            acc_d   = mac_acc;
            ovf_d   = ovf_q | mac_flags.ovf;
            dseen_d = 1'b1;
            epos_d  = pos_next;
          end
        end
      end
    end
  end

  always_comb begin
    result_val = minus_q ? (~acc_q + VALUE_WIDTH'(1)) : acc_q;
    if (ovf_q) begin
      result_val = '1;
    end
  end

  assign out_vld_d = (advance && is_nul) || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      cfg_base_q <= BASE_AUTO;
      phase_q    <= PH_SPACE;
      acc_q      <= '0;
      ovf_q      <= 1'b0;
      minus_q    <= 1'b0;
      abase_q    <= BASE_AUTO;
      dseen_q    <= 1'b0;
      pos_q      <= '0;
      epos_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_base_q <= cfg_data_i;
      end
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      minus_q <= minus_d;
      abase_q <= abase_d;
      dseen_q <= dseen_d;
      pos_q   <= pos_d;
      epos_q  <= epos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= char_byte_i;
    end
    if (advance && is_nul) begin
      value_q <= result_val;
      oor_q   <= ovf_q;
      eoff_q  <= dseen_q ? epos_q : '0;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign value_o        = value_q;
  assign out_of_range_o = oor_q;
  assign end_offset_o   = eoff_q;

endmodule

// ----- rtl/s2u_checker.sv -----
module s2u_checker import s2u_pkg::*; #(
  parameter int unsigned VALUE_WIDTH  = VALUE_WIDTH_DEF,
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic [7:0]              char_byte_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [VALUE_WIDTH-1:0]  value_o,
  input logic                    out_of_range_o,
  input logic [OFFSET_WIDTH-1:0] end_offset_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a fresh result follows a NUL transfer through the input and result registers
  a_result_from_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && char_byte_i == CH_NUL, 2))
    else $error("result without a NUL transfer");

  // range error forces all ones and implies a digit was taken
  a_range_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> (&value_o) && (end_offset_o != '0))
    else $error("range error with bad value or offset");

  // no digits means a zero value
  a_no_digit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_offset_o == '0 |-> value_o == '0 && !out_of_range_o)
    else $error("non-zero result without digits");

endmodule

bind string_to_unsigned_parser s2u_checker #(
  .VALUE_WIDTH (VALUE_WIDTH),
  .OFFSET_WIDTH(OFFSET_WIDTH)
) u_s2u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .char_byte_i   (char_byte_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .value_o       (value_o),
  .out_of_range_o(out_of_range_o),
  .end_offset_o  (end_offset_o)
);
